>>> hdl/lkvc_pkg.sv
package lkvc_pkg;

   localparam int FUNC_W       = 2;
   localparam int KEY_W        = 32;
   localparam int VALUE_W      = 32;
   localparam int CAPACITY_DEF = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_ERASE  = 2'd2
   } func_type;

endpackage

>>> hdl/lkvc_req_if.sv
interface lkvc_req_if;
   import lkvc_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] price_in;

   modport source (output valid, func, key, price_in, input ready);
   modport sink   (input valid, func, key, price_in, output ready);
endinterface

>>> hdl/lkvc_rsp_if.sv
interface lkvc_rsp_if;
   import lkvc_pkg::*;

   logic               valid;
   logic               ready;
   logic               found;
   logic [VALUE_W-1:0] price_out;

   modport source (output valid, found, price_out, input ready);
   modport sink   (input valid, found, price_out, output ready);
endinterface

>>> hdl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Each item on req_if is one operation (lookup, insert, erase) and gives
// exactly one item on rsp_if. One item is taken per clock cycle while rsp_if
// is not stalled; an accepted item is held in the input register, and its
// result is then held in the result register that drives rsp_if. The
// rate is set by the key compare against every entry at once and the
// parallel update of all age ranks. Keys, valid bits and ranks sit in
// flip-flops; values sit in a RAM read at the hit entry. Valid bits and
// ranks clear at reset, so no clearing pass is needed. Func code three does
// nothing and reports not found.
module lru_key_value_cache #(
   parameter int Capacity = lkvc_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lkvc_req_if.sink   req_if,
   lkvc_rsp_if.source rsp_if
);
   import lkvc_pkg::*;

   localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam logic [IdxW-1:0] MaxRank = IdxW'(Capacity - 1);

   // input register
   logic               req_valid_ff, req_valid_in;
   func_type           func_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] price_ff;

   // entry state
   logic [Capacity-1:0] valid_ff, valid_in;
   logic [IdxW-1:0]     rank_ff [Capacity];
   logic [IdxW-1:0]     rank_in [Capacity];
   logic [KEY_W-1:0]    entry_key_ff [Capacity];

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic found_ff, found_in;
   logic hit_rd_ff, hit_rd_in;

   logic               advance, fire, req_take;
   logic [Capacity-1:0] match;
   logic               hit;
   logic [IdxW-1:0]    hit_idx, hit_rank;
   logic               full, have_victim, have_free;
   logic [IdxW-1:0]    victim_idx, free_idx, target;
   logic               target_ok, ins_we;
   logic [VALUE_W-1:0] ram_rd_data;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !req_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;
   assign fire         = req_valid_ff && advance;

   // parallel compare and searches
   always_comb begin
      match       = '0;
      hit_idx     = '0;
      hit_rank    = '0;
      victim_idx  = '0;
      have_victim = 1'b0;
      free_idx    = '0;
      have_free   = 1'b0;
      for (int i = 0; i < Capacity; i++) begin
         match[i] = valid_ff[i] && (entry_key_ff[i] == key_ff);
         if (match[i]) begin
            hit_idx  = IdxW'(i);
            hit_rank = rank_ff[i];
         end
         if (valid_ff[i] && (rank_ff[i] == MaxRank)) begin
            victim_idx  = IdxW'(i);
            have_victim = 1'b1;
         end
      end
      // lowest-numbered free slot wins
      for (int i = Capacity - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx  = IdxW'(i);
            have_free = 1'b1;
         end
      end
   end

   assign hit       = |match;
   assign full      = &valid_ff;
   assign target    = full ? victim_idx : free_idx;
   assign target_ok = full ? have_victim : have_free;
   assign ins_we    = fire && (func_ff == FUNC_INSERT) && !hit && target_ok;

   // rank and valid update
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < Capacity; i++) begin
         rank_in[i] = rank_ff[i];
      end
      found_in  = found_ff;
      hit_rd_in = hit_rd_ff;
      if (fire) begin
         found_in  = 1'b0;
         hit_rd_in = 1'b0;
         unique case (func_ff)
            FUNC_LOOKUP, FUNC_INSERT: begin
               if (hit) begin
                  found_in  = 1'b1;
                  hit_rd_in = (func_ff == FUNC_LOOKUP);
                  for (int i = 0; i < Capacity; i++) begin
                     if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                        rank_in[i] = rank_ff[i] + IdxW'(1);
                     end
                  end
                  rank_in[hit_idx] = '0;
               end else if (ins_we) begin
                  // evicted entry's rank steps past MaxRank here but is overwritten below
                  for (int i = 0; i < Capacity; i++) begin
                     if (valid_ff[i]) begin
                        rank_in[i] = rank_ff[i] + IdxW'(1);
                     end
                  end
                  valid_in[target] = 1'b1;
                  rank_in[target]  = '0;
               end
            end
            FUNC_ERASE: begin
               if (hit) begin
                  found_in = 1'b1;
                  for (int i = 0; i < Capacity; i++) begin
                     if (valid_ff[i] && (rank_ff[i] > hit_rank)) begin
                        rank_in[i] = rank_ff[i] - IdxW'(1);
                     end
                  end
                  valid_in[hit_idx] = 1'b0;
                  rank_in[hit_idx]  = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign req_valid_in = req_if.ready ? req_if.valid : req_valid_ff;
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         for (int i = 0; i < Capacity; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         for (int i = 0; i < Capacity; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff  <= func_type'(req_if.func);
         key_ff   <= req_if.key;
         price_ff <= req_if.price_in;
      end
      if (ins_we) begin
         entry_key_ff[target] <= key_ff;
      end
      found_ff  <= found_in;
      hit_rd_ff <= hit_rd_in;
   end

   lkvc_ram #(
      .Width (VALUE_W),
      .Depth (Capacity)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ins_we),
      .wr_addr (target),
      .wr_data (price_ff),
      .rd_en   (fire),
      .rd_addr (hit_idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.found     = found_ff;
   assign rsp_if.price_out = hit_rd_ff ? ram_rd_data : '0;
endmodule

>>> hdl/lkvc_ram.sv
module lkvc_ram #(
   parameter int Width = lkvc_pkg::VALUE_W,
   parameter int Depth = lkvc_pkg::CAPACITY_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                       rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
